// ----- rtl/core/fc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR full convolution package
// Shared constants, command kinds and stage bundles.
// ----------------------------------------------------------------------------
package fc_pkg;

    localparam int TAPS     = 64;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int VALUE_W  = 16;
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 6;
    localparam int TC_W     = 7;
    localparam int OUT_W    = 38;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int TAIL_W   = $clog2(TAPS);
    localparam int LEVELS   = $clog2(TAPS);
    localparam int TREE_N   = 1 << LEVELS;
    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

    localparam logic [TC_W-1:0] TC_RESET = 7'd64;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_SAMPLE,
        KIND_FLUSH
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [IDX_W-1:0]           idx;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic vld;
        logic last;
    } t_prod_ctrl;

endpackage
`default_nettype wire

// ----- rtl/core/fc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface fc_in_if;
    import fc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [IDX_W-1:0]           coef_index;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output func, output coef_index, output value,
                    input ready);
    modport sink   (input valid, input func, input coef_index, input value,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR output channel
// Valid/ready channel carrying one filter result.
// ----------------------------------------------------------------------------
interface fc_out_if;
    import fc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OUT_W-1:0]    filtered;
    logic                       last;

    modport source (output valid, output filtered, output last, input ready);
    modport sink   (input valid, input filtered, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR front end
// Accepts input transfers, classifies them and drops those with no effect.
// ----------------------------------------------------------------------------
module fc_front (
    fc_in_if.sink           i_in,
    input  wire logic       i_full,
    output fc_pkg::t_cmd    o_cmd,
    output logic            o_push
);
    import fc_pkg::*;

    logic keep;

    always_comb begin
        o_cmd.idx   = i_in.coef_index;
        o_cmd.value = i_in.value;
        o_cmd.kind  = KIND_SAMPLE;
        keep        = 1'b0;
        case (i_in.func)
            FUNC_LOAD: begin
                o_cmd.kind = KIND_LOAD;
                keep       = (int'(i_in.coef_index) < TAPS);
            end
            FUNC_SAMPLE: begin
                o_cmd.kind = KIND_SAMPLE;
                keep       = 1'b1;
            end
            FUNC_FLUSH: begin
                o_cmd.kind = KIND_FLUSH;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Drop unused codes, still taking the transfer
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && keep;

endmodule
`default_nettype wire

// ----- rtl/core/fc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR command queue
// Short FIFO between the front end and the filter engine.
// ----------------------------------------------------------------------------
module fc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  fc_pkg::t_cmd        i_cmd,
    output logic                o_full,
    output logic                o_valid,
    output fc_pkg::t_cmd        o_cmd,
    input  wire logic           i_pop
);
    import fc_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_pop;

    assign o_full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/fc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR filter engine
// Coefficient registers, delay line, flush sequencer and tap multipliers.
// ----------------------------------------------------------------------------
module fc_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fc_pkg::TC_W-1:0]        i_cfg_wdata,
    input  wire logic                           i_en,
    input  wire logic                           i_q_valid,
    input  fc_pkg::t_cmd                        i_q_cmd,
    output logic                                o_pop,
    output logic signed [fc_pkg::PROD_W-1:0]    o_prod [fc_pkg::TAPS],
    output fc_pkg::t_prod_ctrl                  o_ctrl
);
    import fc_pkg::*;

    logic signed [COEF_W-1:0]   r_coef [TAPS];
    logic signed [SAMPLE_W-1:0] r_hist [TAPS-1];
    logic signed [PROD_W-1:0]   r_prod [TAPS];
    logic [TC_W-1:0]            r_taps;
    logic                       r_flush;
    logic [TAIL_W-1:0]          r_tail;
    t_prod_ctrl                 r_ctrl;

    logic                       do_push;
    logic                       do_last;
    logic                       do_clear;
    logic                       flush_start;
    logic signed [SAMPLE_W-1:0] x;
    logic [TC_W-1:0]            taps_clamped;
    logic                       tail_end;

    // Clamp the tap count once, when it is written
    always_comb begin
        if (i_cfg_wdata == '0) begin
            taps_clamped = TC_W'(1);
        end else if (int'(i_cfg_wdata) > TAPS) begin
            taps_clamped = TC_W'(TAPS);
        end else begin
            taps_clamped = i_cfg_wdata;
        end
    end

    assign tail_end = ({1'b0, r_tail} + TC_W'(2)) == r_taps;

    always_comb begin
        o_pop       = i_en && !r_flush;
        do_push     = 1'b0;
        do_last     = 1'b0;
        do_clear    = 1'b0;
        flush_start = 1'b0;
        x           = '0;
        if (r_flush) begin
            do_push  = 1'b1;
            do_last  = tail_end;
            do_clear = tail_end;
        end else if (i_q_valid) begin
            case (i_q_cmd.kind)
                KIND_SAMPLE: begin
                    do_push = 1'b1;
                    x       = i_q_cmd.value[SAMPLE_W-1:0];
                end
                KIND_FLUSH: begin
                    if (r_taps == TC_W'(1)) begin
                        do_clear = 1'b1;
                    end else begin
                        flush_start = 1'b1;
                    end
                end
                default: begin
                    do_push = 1'b0;
                end
            endcase
        end
    end

    // Coefficient writes: one load per cycle at most
    always_ff @(posedge i_clk) begin
        if (i_en && !r_flush && i_q_valid && i_q_cmd.kind == KIND_LOAD) begin
            r_coef[i_q_cmd.idx] <= i_q_cmd.value[COEF_W-1:0];
        end
    end

    // Tap products; taps beyond the count in use contribute zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[0] <= r_coef[0] * x;
            for (int k = 1; k < TAPS; k++) begin
                if (TC_W'(k) < r_taps) begin
                    r_prod[k] <= r_coef[k] * r_hist[k-1];
                end else begin
                    r_prod[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS-1; k++) begin
                r_hist[k] <= '0;
            end
            r_taps  <= TC_RESET;
            r_flush <= 1'b0;
            r_tail  <= '0;
            r_ctrl  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_taps <= taps_clamped;
            end
            if (i_en) begin
                r_ctrl.vld  <= do_push;
                r_ctrl.last <= do_last;
                if (do_clear) begin
                    for (int k = 0; k < TAPS-1; k++) begin
                        r_hist[k] <= '0;
                    end
                end else if (do_push) begin
                    r_hist[0] <= x;
                    for (int k = 1; k < TAPS-1; k++) begin
                        r_hist[k] <= r_hist[k-1];
                    end
                end
                if (flush_start) begin
                    r_flush <= 1'b1;
                    r_tail  <= '0;
                end else if (r_flush) begin
                    if (tail_end) begin
                        r_flush <= 1'b0;
                        r_tail  <= '0;
                    end else begin
                        r_tail <= r_tail + 1'b1;
                    end
                end
            end
        end
    end

    assign o_prod = r_prod;
    assign o_ctrl = r_ctrl;

    // Tail counter never passes the final tail output
    a_tail_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (({1'b0, r_tail} + TC_W'(2)) <= r_taps))
        else $error("tail counter beyond tap count");

    // Delay line is empty after the last tail output
    a_clear_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush && tail_end && i_en) |=> (r_hist[0] == '0 && !r_flush))
        else $error("delay line not cleared after flush");

    // A stalled engine holds its sequencing state
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_en && !i_cfg_we) |=> ($stable(r_ctrl) && $stable(r_tail) && $stable(r_flush)))
        else $error("engine state moved during stall");

    // The last mark only ever rides on a valid product set
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.last |-> r_ctrl.vld)
        else $error("last mark without valid products");

endmodule
`default_nettype wire

// ----- rtl/core/fc_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR summation tree
// Registered binary adder tree; its root is the output register.
// ----------------------------------------------------------------------------
module fc_sum (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic signed [fc_pkg::PROD_W-1:0] i_prod [fc_pkg::TAPS],
    input  fc_pkg::t_prod_ctrl                  i_ctrl,
    output logic                                o_en,
    fc_out_if.source                            o_out
);
    import fc_pkg::*;

    logic signed [OUT_W-1:0]    r_node [TREE_N-1];
    logic signed [OUT_W-1:0]    all_n  [2*TREE_N-1];
    logic [LEVELS-1:0]          r_vld;
    logic [LEVELS-1:0]          r_last;

    // Heap layout: internal nodes first, sign-extended leaves after
    always_comb begin
        for (int i = 0; i < TREE_N-1; i++) begin
            all_n[i] = r_node[i];
        end
        for (int j = 0; j < TREE_N; j++) begin
            if (j < TAPS) begin
                all_n[TREE_N-1+j] = OUT_W'(i_prod[j]);
            end else begin
                all_n[TREE_N-1+j] = '0;
            end
        end
    end

    // Advance the whole pipeline unless a result waits on the output
    assign o_en = !r_vld[LEVELS-1] || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            for (int i = 0; i < TREE_N-1; i++) begin
                r_node[i] <= all_n[2*i+1] + all_n[2*i+2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_last <= '0;
        end else if (o_en) begin
            r_vld  <= LEVELS'({r_vld, i_ctrl.vld});
            r_last <= LEVELS'({r_last, i_ctrl.last});
        end
    end

    assign o_out.valid    = r_vld[LEVELS-1];
    assign o_out.last     = r_last[LEVELS-1];
    assign o_out.filtered = r_node[0];

endmodule
`default_nettype wire

// ----- rtl/core/fir_full_convolution.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR full linear convolution filter
// Direct-form FIR with coefficient loads, sample pushes and tail flush.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries commands: load (coefficient into tap coef_index), sample
//   (push one Q1.15 sample, one Q8.30 result) and flush (tap_count-1 tail
//   results, the final one with last set, then the delay line is cleared).
//   o_out carries results. i_cfg_we/i_cfg_wdata set the tap count; write it
//   only while the filter is idle.
// Throughput: one transfer per cycle on i_in while i_in.ready is high.
//   A flush keeps the engine busy (a set-up step, then one tail result per
//   cycle unless o_out stalls); the command queue fills meanwhile and
//   i_in.ready drops when it is full.
// Pipeline: a sample result is registered in the queue, then in the tap
//   multipliers and then once per level of the registered adder tree.
// Reset: synchronous, active low. Clears the delay line, the queue and the
//   pipeline valids and sets tap_count to 64; coefficients must be loaded.
// Stall: while o_out holds a result that is not taken, the whole engine and
//   tree hold; the queue absorbs up to four commands before i_in stalls.
// ----------------------------------------------------------------------------
module fir_full_convolution (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [fc_pkg::TC_W-1:0]    i_cfg_wdata,
    fc_in_if.sink                           i_in,
    fc_out_if.source                        o_out
);
    import fc_pkg::*;

    t_cmd                       front_cmd;
    logic                       front_push;
    logic                       q_full;
    logic                       q_valid;
    t_cmd                       q_cmd;
    logic                       pop;
    logic                       en;
    logic signed [PROD_W-1:0]   prod [TAPS];
    t_prod_ctrl                 prod_ctrl;

    // Classify incoming transfers; drop those that do nothing
    fc_front u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_cmd  (front_cmd),
        .o_push (front_push)
    );

    // Decouple acceptance from the engine so each side can stall alone
    fc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    // Coefficients, delay line, flush sequencing and tap products
    fc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_en        (en),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_prod      (prod),
        .o_ctrl      (prod_ctrl)
    );

    // Sum the products; the tree root drives the output channel
    fc_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (prod),
        .i_ctrl  (prod_ctrl),
        .o_en    (en),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
